// ===== design/mail_address_list_extractor_defines.svh =====
// assertion macros shared by the rtl files
`ifndef MAIL_ADDRESS_LIST_EXTRACTOR_DEFINES_SVH
`define MAIL_ADDRESS_LIST_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MAL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mal same-cycle check failed");
`define MAL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mal next-cycle check failed");
`else
`define MAL_ASSERT_IMP(label, clk, rst, ante, cons)
`define MAL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/mal_pkg.sv =====
`timescale 1ns / 1ps

package mal_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] SJIS_LEAD_MIN = 8'h81;

  typedef enum logic [1:0] {
    PH_SINGLE = 2'd0,
    PH_LEAD   = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_UNUSED = 2'd3
  } sjis_phase_t;

  typedef struct packed {
    logic        escape_pending;
    logic        saw_angle;
    logic        inside_angle;
    logic        inside_comment;
    logic        comment_is_quote;
    logic        comment_escape;
    sjis_phase_t sjis_phase;
    logic        address_nonempty;
  } parse_state_t;

  typedef struct packed {
    logic       text_end;
    logic       address_end;
    logic       discard_before;
    logic [7:0] addr_byte;
    logic       byte_valid;
  } result_t;

endpackage

// ===== design/mal_parser.sv =====
`timescale 1ns / 1ps
`include "mail_address_list_extractor_defines.svh"

module mal_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             beat,
  input  logic [7:0]       text_byte,
  input  logic             text_last,
  output mal_pkg::result_t res
);
  import mal_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  sjis_phase_t  ph;
  logic [7:0]   closer;
  logic         append;
  logic         discard;
  logic         aend;

  always_comb begin
    st_next = st;
    append  = 1'b0;
    discard = 1'b0;
    aend    = 1'b0;
    closer  = st.comment_is_quote ? CH_QUOTE : CH_RPAREN;
    ph      = (st.sjis_phase == PH_LEAD) ? PH_TRAIL :
              ((text_byte >= SJIS_LEAD_MIN) ? PH_LEAD : PH_SINGLE);

    priority if (st.inside_comment) begin
      st_next.sjis_phase = ph;
      if (ph == PH_SINGLE && text_byte == CH_BSLASH) begin
        st_next.comment_escape = ~st.comment_escape;
      end else if (!st.comment_escape && text_byte == closer) begin
        st_next.inside_comment = 1'b0;
        st_next.comment_escape = 1'b0;
        st_next.sjis_phase     = PH_SINGLE;
      end else begin
        st_next.comment_escape = 1'b0;
      end
    end else if (st.escape_pending) begin
      st_next.escape_pending = 1'b0;
      append = 1'b1;
    end else if (text_byte == CH_LPAREN || text_byte == CH_QUOTE) begin
      st_next.inside_comment   = 1'b1;
      st_next.comment_is_quote = (text_byte == CH_QUOTE);
      st_next.comment_escape   = 1'b0;
      st_next.sjis_phase       = PH_SINGLE;
    end else if (text_byte == CH_BSLASH) begin
      st_next.escape_pending = 1'b1;
      append = 1'b1;
    end else if (text_byte == CH_LT) begin
      discard = 1'b1;
      st_next.address_nonempty = 1'b0;
      st_next.saw_angle        = 1'b1;
      st_next.inside_angle     = 1'b1;
    end else if (text_byte == CH_GT) begin
      aend = 1'b1;
      st_next.address_nonempty = 1'b0;
      st_next.inside_angle     = 1'b0;
    end else if (text_byte == CH_COMMA) begin
      aend = st.address_nonempty;
      st_next.address_nonempty = 1'b0;
      st_next.saw_angle        = 1'b0;
    end else if (st.saw_angle) begin
      append = st.inside_angle;
    end else begin
      append = (text_byte != CH_SPACE) && (text_byte != CH_LF) && (text_byte != CH_CR);
    end

    if (append) begin
      st_next.address_nonempty = 1'b1;
    end

    if (text_last) begin
      aend    = aend | st_next.address_nonempty;
      st_next = '0;
    end

    res.byte_valid     = append;
    res.addr_byte      = append ? text_byte : 8'h00;
    res.discard_before = discard;
    res.address_end    = aend;
    res.text_end       = text_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (beat) begin
      st <= st_next;
    end
  end

  `MAL_ASSERT_NXT(a_last_clears, clk, rst, beat && text_last, st == '0)
  `MAL_ASSERT_IMP(a_comment_silent, clk, rst, beat && st.inside_comment, !res.byte_valid && !res.discard_before && (res.address_end == text_last && st.address_nonempty || !res.address_end))
  `MAL_ASSERT_IMP(a_discard_alone, clk, rst, beat && res.discard_before, !res.byte_valid && st_next.saw_angle == !text_last)

endmodule

// ===== design/mal_skid.sv =====
`timescale 1ns / 1ps
`include "mail_address_list_extractor_defines.svh"

module mal_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mal_pkg::result_t in_res,
  output logic             out_valid,
  input  logic             out_ready,
  output mal_pkg::result_t out_res
);
  import mal_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    in_beat;
  logic    to_skid;

  assign in_ready = !skid_valid;
  assign in_beat  = in_valid && in_ready;
  assign to_skid  = in_beat && out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_beat) begin
      if (to_skid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && to_skid) begin
      skid_res <= in_res;
    end
    if (in_beat && !to_skid) begin
      out_res <= in_res;
    end else if (!in_beat && out_ready && skid_valid) begin
      out_res <= skid_res;
    end
  end

  `MAL_ASSERT_IMP(a_skid_behind_main, clk, rst, skid_valid, out_valid)
  `MAL_ASSERT_NXT(a_stall_fills_skid, clk, rst, in_beat && out_valid && !out_ready, skid_valid)
  `MAL_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && out_ready, !skid_valid && out_valid)

endmodule

// ===== design/mail_address_list_extractor.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata                          | tlast     | tuser
// s_axis  | in  | [7:0] text_byte                | text_last | -
// m_axis  | out | [0] byte_valid [8:1] addr_byte | text_end  | -
//         |     | [9] discard_before             |           |
//         |     | [10] address_end [15:11] zero  |           |
// one beat per cycle sustained while m_tready is high; a beat's result is formed by
// the single combinational parser stage and registered into the output slots
// rst is synchronous and clears parser state and both output slots
// a two-slot output buffer holds one extra result while m_tready is low; s_tready drops only while
// both slots are full
`include "mail_address_list_extractor_defines.svh"

module mail_address_list_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // text_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // byte_valid, addr_byte, discard_before, address_end
  output logic        m_tlast
);
  import mal_pkg::*;

  logic    s_beat;
  result_t step_res;
  result_t out_res;

  assign s_beat = s_tvalid && s_tready;

  mal_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (s_beat),
    .text_byte (s_tdata),
    .text_last (s_tlast),
    .res       (step_res)
  );

  mal_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_res    (step_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {5'b00000, out_res.address_end, out_res.discard_before,
                    out_res.addr_byte, out_res.byte_valid};
  assign m_tlast = out_res.text_end;

endmodule
